// ----- src/xor_checked_frame_receiver_assert.svh -----
// Assertion macros for the frame receiver.
// Each macro checks a property on the rising clock edge and is disabled in reset.
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCFR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define XCFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- src/xcfr_pkg.sv -----
`timescale 1ns / 1ps

package xcfr_pkg;

    localparam int unsigned FRAME_LEN  = 6;
    localparam int unsigned STORE_LEN  = FRAME_LEN - 1;
    localparam int unsigned CNT_W      = 3;

    localparam logic [7:0] HEADER_MAX  = 8'd15;

    localparam logic [7:0] HDR_HEARTBEAT = 8'd0;
    localparam logic [7:0] HDR_MOTOR     = 8'd2;
    localparam logic [7:0] HDR_SENSOR    = 8'd4;

    localparam logic [7:0] HB_PAT_1 = 8'h12;
    localparam logic [7:0] HB_PAT_2 = 8'h34;
    localparam logic [7:0] HB_PAT_3 = 8'h56;
    localparam logic [7:0] HB_PAT_4 = 8'h78;

    localparam logic [7:0] SR_PAT_1 = 8'hAA;
    localparam logic [7:0] SR_PAT_2 = 8'hBB;
    localparam logic [7:0] SR_PAT_3 = 8'hCC;
    localparam logic [7:0] SR_PAT_4 = 8'hDD;

    typedef enum logic [2:0] {
        EV_WAIT       = 3'd0,
        EV_BAD_HEADER = 3'd1,
        EV_BAD_SUM    = 3'd2,
        EV_HEARTBEAT  = 3'd3,
        EV_MOTOR      = 3'd4,
        EV_SENSOR     = 3'd5,
        EV_IGNORED    = 3'd6
    } event_t;

    typedef struct packed {
        logic [15:0] right_speed;
        logic [15:0] left_speed;
        event_t      event_res;
    } result_t;

    localparam int unsigned RES_W   = $bits(result_t);
    localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ----- src/xor_checked_frame_receiver.sv -----
`timescale 1ns / 1ps

// Channel | Ports                  | tdata, lowest bit first
// --------+------------------------+---------------------------------------------
// s_ in   | s_tvalid s_tready      | rx_byte[7:0]
// m_ out  | m_tvalid m_tready      | event_res[2:0] left_speed[18:3]
//         |                        | right_speed[34:19], zero pad [39:35]
//
// One byte per cycle while m_ is not stalled: the window check and decode sit
// between the byte register window and the result register, so each result
// appears in the cycle after its byte transfer. The single result register
// sets the rate: a new byte is taken whenever that register is empty or being drained.
// aresetn (synchronous, active low) empties the window and zeroes both speeds.
// A stall on m_ holds the result and stalls s_ in the same cycle.

`include "xor_checked_frame_receiver_assert.svh"

module xor_checked_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // rx_byte[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_res[2:0], left_speed[18:3], right_speed[34:19], zeros above
    output logic [xcfr_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned STORE_LEN = xcfr_pkg::STORE_LEN;
    localparam int unsigned CNT_W     = xcfr_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_LEN);

    logic [7:0]       win_reg [STORE_LEN];
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      right_reg, right_next;
    logic             m_tvalid_reg;
    xcfr_pkg::result_t res_reg, res_next;

    logic             s_xfer;
    logic             full;
    logic             shift;
    logic [7:0]       hdr;
    logic [7:0]       sum;
    logic             hb_match;
    logic             sr_match;
    xcfr_pkg::event_t ev_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(xcfr_pkg::M_TDATA_W - xcfr_pkg::RES_W){1'b0}}, res_reg};

    // The incoming byte completes the frame when five are already held.
    assign full = (held_count_reg == CNT_FULL);
    assign hdr  = win_reg[0];
    assign sum  = win_reg[0] ^ win_reg[1] ^ win_reg[2] ^ win_reg[3] ^ win_reg[4];

    assign hb_match = (win_reg[1] == xcfr_pkg::HB_PAT_1) && (win_reg[2] == xcfr_pkg::HB_PAT_2)
                   && (win_reg[3] == xcfr_pkg::HB_PAT_3) && (win_reg[4] == xcfr_pkg::HB_PAT_4);
    assign sr_match = (win_reg[1] == xcfr_pkg::SR_PAT_1) && (win_reg[2] == xcfr_pkg::SR_PAT_2)
                   && (win_reg[3] == xcfr_pkg::SR_PAT_3) && (win_reg[4] == xcfr_pkg::SR_PAT_4);

    always_comb begin
        ev_next         = xcfr_pkg::EV_WAIT;
        held_count_next = CNT_W'(held_count_reg + 1'b1);
        shift           = 1'b0;
        left_next       = left_reg;
        right_next      = right_reg;
        if (full) begin
            held_count_next = CNT_FULL;
            if (hdr > xcfr_pkg::HEADER_MAX) begin
                ev_next = xcfr_pkg::EV_BAD_HEADER;
                shift   = 1'b1;
            end else if (sum != s_tdata) begin
                ev_next = xcfr_pkg::EV_BAD_SUM;
                shift   = 1'b1;
            end else begin
                // Consume the whole frame; stale bytes are overwritten before use.
                held_count_next = '0;
                ev_next         = xcfr_pkg::EV_IGNORED;
                case (hdr)
                    xcfr_pkg::HDR_HEARTBEAT: begin
                        if (hb_match) ev_next = xcfr_pkg::EV_HEARTBEAT;
                    end
                    xcfr_pkg::HDR_MOTOR: begin
                        left_next  = {win_reg[1], win_reg[2]};
                        right_next = {win_reg[3], win_reg[4]};
                        ev_next    = xcfr_pkg::EV_MOTOR;
                    end
                    xcfr_pkg::HDR_SENSOR: begin
                        if (sr_match) ev_next = xcfr_pkg::EV_SENSOR;
                    end
                    default: ev_next = xcfr_pkg::EV_IGNORED;
                endcase
            end
        end
        res_next.event_res   = ev_next;
        res_next.left_speed  = left_next;
        res_next.right_speed = right_next;
    end

    // Window bytes need no reset: the fill count guards every read.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            if (shift) begin
                // Drop the oldest byte and append the new one.
                for (int i = 0; i < STORE_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[STORE_LEN-1] <= s_tdata;
            end else if (!full) begin
                for (int i = 0; i < STORE_LEN; i++) begin
                    if (held_count_reg == CNT_W'(i)) win_reg[i] <= s_tdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (s_xfer) begin
                held_count_reg <= held_count_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) res_reg <= res_next;
    end

    `XCFR_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, held_count_reg <= CNT_FULL)
    `XCFR_ASSERT_NEXT(a_partial_waits, aclk, aresetn, s_xfer && !full,
                      res_reg.event_res == xcfr_pkg::EV_WAIT)
    `XCFR_ASSERT_NEXT(a_frame_empties, aclk, aresetn,
                      s_xfer && full && hdr <= xcfr_pkg::HEADER_MAX && sum == s_tdata,
                      held_count_reg == '0)
    `XCFR_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid_reg, s_tready)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = 8'h00;  // rx_byte[7:0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // event_res[2:0], left_speed[18:3], right_speed[34:19], zeros above
    logic [xcfr_pkg::M_TDATA_W-1:0] m_tdata;

    xor_checked_frame_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Tracks the receive window and the motor values, and keeps the events
    // still owed by the block in transfer order.
    class frame_tracker;
        logic [7:0]        win [xcfr_pkg::FRAME_LEN];
        int unsigned       held;
        logic [15:0]       left_val;
        logic [15:0]       right_val;
        xcfr_pkg::result_t owed_events [$];
        int unsigned       mismatches;

        function new();
            foreach (win[i]) win[i] = 8'h00;
            held        = 0;
            left_val    = 16'h0000;
            right_val   = 16'h0000;
            mismatches  = 0;
        endfunction

        function void shift_out_oldest();
            for (int i = 0; i < xcfr_pkg::FRAME_LEN - 1; i++) win[i] = win[i + 1];
            win[xcfr_pkg::FRAME_LEN - 1] = 8'h00;
            held = xcfr_pkg::FRAME_LEN - 1;
        endfunction

        function void decode_byte(logic [7:0] rx);
            int unsigned      pos;
            logic [7:0]       sum;
            xcfr_pkg::event_t ev;
            pos = (held >= xcfr_pkg::FRAME_LEN) ? xcfr_pkg::FRAME_LEN - 1 : held;
            win[pos] = rx;
            held = pos + 1;
            ev = xcfr_pkg::EV_WAIT;
            if (held == xcfr_pkg::FRAME_LEN) begin
                sum = win[0] ^ win[1] ^ win[2] ^ win[3] ^ win[4];
                if (win[0] > xcfr_pkg::HEADER_MAX) begin
                    shift_out_oldest();
                    ev = xcfr_pkg::EV_BAD_HEADER;
                end else if (sum != win[5]) begin
                    shift_out_oldest();
                    ev = xcfr_pkg::EV_BAD_SUM;
                end else begin
                    ev = xcfr_pkg::EV_IGNORED;
                    if (win[0] == xcfr_pkg::HDR_HEARTBEAT) begin
                        if (win[1] == xcfr_pkg::HB_PAT_1 && win[2] == xcfr_pkg::HB_PAT_2 &&
                            win[3] == xcfr_pkg::HB_PAT_3 && win[4] == xcfr_pkg::HB_PAT_4)
                            ev = xcfr_pkg::EV_HEARTBEAT;
                    end else if (win[0] == xcfr_pkg::HDR_MOTOR) begin
                        left_val  = {win[1], win[2]};
                        right_val = {win[3], win[4]};
                        ev = xcfr_pkg::EV_MOTOR;
                    end else if (win[0] == xcfr_pkg::HDR_SENSOR) begin
                        if (win[1] == xcfr_pkg::SR_PAT_1 && win[2] == xcfr_pkg::SR_PAT_2 &&
                            win[3] == xcfr_pkg::SR_PAT_3 && win[4] == xcfr_pkg::SR_PAT_4)
                            ev = xcfr_pkg::EV_SENSOR;
                    end
                    foreach (win[i]) win[i] = 8'h00;
                    held = 0;
                end
            end
            owed_events.push_back('{right_speed: right_val, left_speed: left_val,
                                    event_res: ev});
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input logic [xcfr_pkg::M_TDATA_W-1:0] data);
            xcfr_pkg::result_t got;
            xcfr_pkg::result_t want;
            got = xcfr_pkg::result_t'(data[xcfr_pkg::RES_W-1:0]);
            if (owed_events.size() == 0) begin
                report($sformatf("unexpected result tdata=%h", data));
                return;
            end
            want = owed_events.pop_front();
            if (got.event_res !== want.event_res)
                report($sformatf("event_res got %0d want %0d", got.event_res,
                                 want.event_res));
            if (got.left_speed !== want.left_speed)
                report($sformatf("left_speed got %h want %h", got.left_speed,
                                 want.left_speed));
            if (got.right_speed !== want.right_speed)
                report($sformatf("right_speed got %h want %h", got.right_speed,
                                 want.right_speed));
        endtask
    endclass

    frame_tracker tracker;
    int unsigned  bytes_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  cyc        = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver stall pattern: phases of free flow, random stalls and sparse ready.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        case ((cyc / 377) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (cyc % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.decode_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    task send_byte(input logic [7:0] rx);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    // Send header, four payload bytes and the XOR checksum, optionally corrupted.
    task send_frame(input logic [7:0] hdr, input logic [7:0] p1, input logic [7:0] p2,
                    input logic [7:0] p3, input logic [7:0] p4, input bit corrupt);
        logic [7:0] sum;
        sum = hdr ^ p1 ^ p2 ^ p3 ^ p4;
        if (corrupt) sum = sum ^ (8'h01 << $urandom_range(0, 7));
        send_byte(hdr);
        send_byte(p1);
        send_byte(p2);
        send_byte(p3);
        send_byte(p4);
        send_byte(sum);
    endtask

    // Hold the sender until every owed event has been transferred.
    task drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (tracker.owed_events.size() != 0);
    endtask

    initial begin
        logic [7:0] hdr;
        int unsigned pick;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Header just above the limit, then resync onto a heartbeat.
        send_byte(8'h10);
        send_frame(xcfr_pkg::HDR_HEARTBEAT, xcfr_pkg::HB_PAT_1, xcfr_pkg::HB_PAT_2,
                   xcfr_pkg::HB_PAT_3, xcfr_pkg::HB_PAT_4, 1'b0);
        send_frame(xcfr_pkg::HDR_MOTOR, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_frame(xcfr_pkg::HDR_SENSOR, xcfr_pkg::SR_PAT_1, xcfr_pkg::SR_PAT_2,
                   xcfr_pkg::SR_PAT_3, xcfr_pkg::SR_PAT_4, 1'b0);
        send_frame(xcfr_pkg::HDR_HEARTBEAT, xcfr_pkg::SR_PAT_1, xcfr_pkg::SR_PAT_2,
                   xcfr_pkg::SR_PAT_3, xcfr_pkg::SR_PAT_4, 1'b0);
        send_frame(xcfr_pkg::HEADER_MAX, 8'h00, 8'hFF, 8'h80, 8'h7F, 1'b1);
        drain_results();

        while (bytes_sent < 1900) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 5))
                    0: send_frame(xcfr_pkg::HDR_HEARTBEAT, xcfr_pkg::HB_PAT_1,
                                  xcfr_pkg::HB_PAT_2, xcfr_pkg::HB_PAT_3,
                                  xcfr_pkg::HB_PAT_4, $urandom_range(0, 9) == 0);
                    1: send_frame(xcfr_pkg::HDR_SENSOR, xcfr_pkg::SR_PAT_1,
                                  xcfr_pkg::SR_PAT_2, xcfr_pkg::SR_PAT_3,
                                  xcfr_pkg::SR_PAT_4, $urandom_range(0, 9) == 0);
                    2, 3: send_frame(xcfr_pkg::HDR_MOTOR, 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom),
                                     $urandom_range(0, 9) == 0);
                    default: begin
                        hdr = 8'($urandom_range(0, 15));
                        send_frame(hdr, 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), $urandom_range(0, 9) == 0);
                    end
                endcase
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 15)));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            if ($urandom_range(0, 99) == 0) drain_results();
        end

        s_tvalid <= 1'b0;
        while (tracker.owed_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.owed_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
